@@ hdl/dsvs_pkg.sv @@
// ----------------------------------------------------------------------------
// Depth-shift view synthesis package
// Shared widths, command codes, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package dsvs_pkg;

    // Default configuration of the row store and the disparity table
    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int DEPTH_BITS_DEF = 16;

    // Fixed field widths
    localparam int CMD_W    = 2;
    localparam int COLUMN_W = 11;
    localparam int CODE_W   = 16;
    localparam int CHAN_W   = 8;
    localparam int COLOR_W  = 3 * CHAN_W;
    localparam int DISP_W   = 16;
    localparam int FRAC_W   = 4;
    localparam int FILL_W   = 4;
    localparam int RWID_W   = 12;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_EXTRA = 1'd1;

    localparam logic [RWID_W-1:0] ROW_WIDTH_RST  = 12'd2048;
    localparam logic [FILL_W-1:0] FILL_EXTRA_RST = 4'd0;

    // Request commands
    typedef enum logic [CMD_W-1:0] {
        CMD_PLACE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_LOAD  = 2'd2
    } cmd_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_FILL,
        ST_READ
    } state_t;

endpackage

@@ hdl/depth_shift_view_synthesis.sv @@
// ----------------------------------------------------------------------------
// Depth-shift view synthesis
// Builds one row of a right-eye view by shifting left-view pixels through a
// loaded disparity table into a row store with coverage marks.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  s_       in         s_valid / s_ready    cmd, column, depth_code, rgb, table_value
//  m_       out        m_valid / m_ready    out_red, out_green, out_blue, covered
//  cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
//  Load writes the table while idle. Place does one table read then one row
//  store write per column: the target plus up to fill_extra neighbors (fewer when
//  clipped at the row end). Read does one row store read then the clearing write.
//  After reset a clearing pass writes zero to every row store entry, with s_ready
//  low. A read whose result finds the output register still full waits in place
//  until m_ready frees it.
//
module depth_shift_view_synthesis #(
    parameter int MAX_WIDTH  = dsvs_pkg::MAX_WIDTH_DEF,
    parameter int DEPTH_BITS = dsvs_pkg::DEPTH_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [dsvs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dsvs_pkg::CFG_DATA_W-1:0]  cfg_data,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [dsvs_pkg::CMD_W-1:0]       s_cmd,
    input  logic [dsvs_pkg::COLUMN_W-1:0]    s_column,
    input  logic [dsvs_pkg::CODE_W-1:0]      s_depth_code,
    input  logic [dsvs_pkg::CHAN_W-1:0]      s_red,
    input  logic [dsvs_pkg::CHAN_W-1:0]      s_green,
    input  logic [dsvs_pkg::CHAN_W-1:0]      s_blue,
    input  logic [dsvs_pkg::DISP_W-1:0]      s_table_value,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [dsvs_pkg::CHAN_W-1:0]      m_out_red,
    output logic [dsvs_pkg::CHAN_W-1:0]      m_out_green,
    output logic [dsvs_pkg::CHAN_W-1:0]      m_out_blue,
    output logic                             m_covered
);

    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int WW          = $clog2(MAX_WIDTH + 1);
    localparam int CW          = ((WW > dsvs_pkg::RWID_W) ? WW : dsvs_pkg::RWID_W) + 1;
    localparam int TABLE_DEPTH = 1 << DEPTH_BITS;
    localparam int ROW_W       = dsvs_pkg::COLOR_W + 1;
    localparam int DIFF_W      = dsvs_pkg::DISP_W + 2;
    localparam int CHAN_W      = dsvs_pkg::CHAN_W;
    localparam int FILL_W      = dsvs_pkg::FILL_W;
    localparam int FRAC_W      = dsvs_pkg::FRAC_W;
    localparam int COLUMN_W    = dsvs_pkg::COLUMN_W;

    // Memories: row store (color in [24:1], mark in [0]) and disparity table
    logic [ROW_W-1:0]              row_mem [MAX_WIDTH];
    logic [dsvs_pkg::DISP_W-1:0]   tbl_mem [TABLE_DEPTH];

    logic [ROW_W-1:0]              row_rd_reg;
    logic [dsvs_pkg::DISP_W-1:0]   tbl_rd_reg;

    // Control and payload registers
    dsvs_pkg::state_t              state_reg, state_next;
    logic [COL_BITS-1:0]           clr_cnt_reg, clr_cnt_next;
    logic [COL_BITS-1:0]           fill_col_reg, fill_col_next;
    logic [FILL_W-1:0]             fill_left_reg, fill_left_next;
    logic [CW-1:0]                 act_width_reg;
    logic [FILL_W-1:0]             fill_extra_reg;
    logic [COLUMN_W-1:0]           col_reg;
    logic [dsvs_pkg::COLOR_W-1:0]  color_reg;
    logic                          read_hit_reg;

    logic                          m_valid_reg;
    logic [CHAN_W-1:0]             out_red_reg, out_green_reg, out_blue_reg;
    logic                          covered_reg;

    // Memory control
    logic                          row_we_color, row_we_mark, row_re;
    logic [COL_BITS-1:0]           row_wr_addr;
    logic [dsvs_pkg::COLOR_W-1:0]  row_wr_color;
    logic                          row_wr_mark;
    logic [COL_BITS-1:0]           row_rd_addr;
    logic                          tbl_we, tbl_re;
    logic [DEPTH_BITS-1:0]         tbl_addr;
    logic                          out_load;
    logic                          s_accept;

    // Target column arithmetic
    logic signed [DIFF_W-1:0]      diff;
    logic [COLUMN_W-1:0]           target;
    logic                          target_ok;
    logic [CW-1:0]                 target_ext, target_p1, fill_p1;
    logic                          place_hit;
    logic [CW-1:0]                 cfg_width_ext;
    logic [CW-1:0]                 s_col_ext;

    assign cfg_ready = 1'b1;
    assign s_accept  = s_valid && s_ready;
    assign tbl_addr  = s_depth_code[DEPTH_BITS-1:0];
    assign s_col_ext = CW'(s_column);
    assign row_rd_addr = s_col_ext[COL_BITS-1:0];

    // Configuration registers; row width is kept already clipped to MAX_WIDTH
    assign cfg_width_ext = CW'(cfg_data[dsvs_pkg::RWID_W-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_width_reg  <= (CW'(dsvs_pkg::ROW_WIDTH_RST) > CW'(MAX_WIDTH)) ?
                              CW'(MAX_WIDTH) : CW'(dsvs_pkg::ROW_WIDTH_RST);
            fill_extra_reg <= dsvs_pkg::FILL_EXTRA_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                dsvs_pkg::CFG_ROW_WIDTH: begin
                    act_width_reg <= (cfg_width_ext > CW'(MAX_WIDTH)) ?
                                     CW'(MAX_WIDTH) : cfg_width_ext;
                end
                dsvs_pkg::CFG_FILL_EXTRA: begin
                    fill_extra_reg <= cfg_data[FILL_W-1:0];
                end
                default: ;
            endcase
        end
    end

    // Disparity table: written on load, read on place
    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            tbl_mem[tbl_addr] <= s_table_value;
        end
        if (tbl_re) begin
            tbl_rd_reg <= tbl_mem[tbl_addr];
        end
    end

    // Row store with separate color and mark write lanes
    always_ff @(posedge aclk) begin
        if (row_we_color) begin
            row_mem[row_wr_addr][ROW_W-1:1] <= row_wr_color;
        end
        if (row_we_mark) begin
            row_mem[row_wr_addr][0] <= row_wr_mark;
        end
        if (row_re) begin
            row_rd_reg <= row_mem[row_rd_addr];
        end
    end

    // Target column: column*16 - disparity, truncated toward zero
    always_comb begin
        diff       = $signed({{(DIFF_W-COLUMN_W-FRAC_W){1'b0}}, col_reg, {FRAC_W{1'b0}}})
                   - $signed({2'b00, tbl_rd_reg});
        target_ok  = 1'b1;
        target     = diff[COLUMN_W+FRAC_W-1:FRAC_W];
        if (diff[DIFF_W-1]) begin
            // small negative result rounds to column zero, larger ones drop
            target_ok = (diff > -$signed(DIFF_W'(16)));
            target    = '0;
        end
        target_ext = CW'(target);
        target_p1  = target_ext + CW'(1);
        fill_p1    = CW'(fill_col_reg) + CW'(1);
        place_hit  = target_ok && (target_ext < act_width_reg);
    end

    // Sequencer: next state and memory control
    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        fill_col_next  = fill_col_reg;
        fill_left_next = fill_left_reg;
        s_ready        = 1'b0;
        row_we_color   = 1'b0;
        row_we_mark    = 1'b0;
        row_re         = 1'b0;
        row_wr_addr    = fill_col_reg;
        row_wr_color   = color_reg;
        row_wr_mark    = 1'b1;
        tbl_we         = 1'b0;
        tbl_re         = 1'b0;
        out_load       = 1'b0;

        unique case (state_reg)
            dsvs_pkg::ST_CLEAR: begin
                row_we_color = 1'b1;
                row_we_mark  = 1'b1;
                row_wr_addr  = clr_cnt_reg;
                row_wr_color = '0;
                row_wr_mark  = 1'b0;
                if (clr_cnt_reg == COL_BITS'(MAX_WIDTH - 1)) begin
                    state_next = dsvs_pkg::ST_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + COL_BITS'(1);
                end
            end
            dsvs_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (s_cmd)
                        dsvs_pkg::CMD_PLACE: begin
                            tbl_re     = 1'b1;
                            state_next = dsvs_pkg::ST_LOOKUP;
                        end
                        dsvs_pkg::CMD_READ: begin
                            row_re     = 1'b1;
                            state_next = dsvs_pkg::ST_READ;
                        end
                        dsvs_pkg::CMD_LOAD: begin
                            tbl_we = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            dsvs_pkg::ST_LOOKUP: begin
                state_next = dsvs_pkg::ST_IDLE;
                if (place_hit) begin
                    row_we_color = 1'b1;
                    row_we_mark  = 1'b1;
                    row_wr_addr  = target_ext[COL_BITS-1:0];
                    if ((fill_extra_reg != '0) && (target_p1 < act_width_reg)) begin
                        fill_col_next  = target_p1[COL_BITS-1:0];
                        fill_left_next = fill_extra_reg - FILL_W'(1);
                        state_next     = dsvs_pkg::ST_FILL;
                    end
                end
            end
            dsvs_pkg::ST_FILL: begin
                // color only; marks of neighbor columns stay as they are
                row_we_color = 1'b1;
                if ((fill_left_reg == '0) || (fill_p1 >= act_width_reg)) begin
                    state_next = dsvs_pkg::ST_IDLE;
                end else begin
                    fill_col_next  = fill_p1[COL_BITS-1:0];
                    fill_left_next = fill_left_reg - FILL_W'(1);
                end
            end
            dsvs_pkg::ST_READ: begin
                // hand over the column and clear it once the output is free
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = dsvs_pkg::ST_IDLE;
                    if (read_hit_reg) begin
                        row_we_color = 1'b1;
                        row_we_mark  = 1'b1;
                        row_wr_addr  = CW'(col_reg) < CW'(MAX_WIDTH) ?
                                       COL_BITS'(CW'(col_reg)) : '0;
                        row_wr_color = '0;
                        row_wr_mark  = 1'b0;
                    end
                end
            end
            default: begin
                state_next = dsvs_pkg::ST_IDLE;
            end
        endcase
    end

    // State and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= dsvs_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            fill_col_reg  <= '0;
            fill_left_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            fill_col_reg  <= fill_col_next;
            fill_left_reg <= fill_left_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Request payload capture
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            col_reg      <= s_column;
            color_reg    <= {s_red, s_green, s_blue};
            read_hit_reg <= (s_col_ext < CW'(MAX_WIDTH));
        end
    end

    // Output register; out-of-range reads give all zero
    always_ff @(posedge aclk) begin
        if (out_load) begin
            if (read_hit_reg) begin
                out_red_reg   <= row_rd_reg[ROW_W-1 -: CHAN_W];
                out_green_reg <= row_rd_reg[ROW_W-1-CHAN_W -: CHAN_W];
                out_blue_reg  <= row_rd_reg[CHAN_W:1];
                covered_reg   <= row_rd_reg[0];
            end else begin
                out_red_reg   <= '0;
                out_green_reg <= '0;
                out_blue_reg  <= '0;
                covered_reg   <= 1'b0;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_red   = out_red_reg;
    assign m_out_green = out_green_reg;
    assign m_out_blue  = out_blue_reg;
    assign m_covered   = covered_reg;

endmodule

@@ bench/tb_depth_shift_view_synthesis.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth-shift view synthesis testbench
// Drives place, read, table-load and unused-command requests with bursty input
// and a stalling output side. A scoreboard keeps its own row store, coverage
// map and disparity table and checks every read result in order.
// ----------------------------------------------------------------------------
module tb_depth_shift_view_synthesis;

    localparam int CMD_W      = dsvs_pkg::CMD_W;
    localparam int COLUMN_W   = dsvs_pkg::COLUMN_W;
    localparam int CODE_W     = dsvs_pkg::CODE_W;
    localparam int CHAN_W     = dsvs_pkg::CHAN_W;
    localparam int COLOR_W    = dsvs_pkg::COLOR_W;
    localparam int DISP_W     = dsvs_pkg::DISP_W;
    localparam int FRAC_W     = dsvs_pkg::FRAC_W;
    localparam int FILL_W     = dsvs_pkg::FILL_W;
    localparam int RWID_W     = dsvs_pkg::RWID_W;
    localparam int CFG_IDX_W  = dsvs_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = dsvs_pkg::CFG_DATA_W;

    localparam int ROW_CAP       = dsvs_pkg::MAX_WIDTH_DEF;
    localparam int LUT_SIZE      = 1 << dsvs_pkg::DEPTH_BITS_DEF;
    localparam int RANDOM_ITEMS  = 1600;
    localparam int PHASE_ITEMS   = 200;
    localparam int SETTLE_CYCLES = 40;       // outlasts the longest place
    localparam int CYCLE_LIMIT   = 500000;
    localparam int REPORT_MAX    = 10;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [COLUMN_W-1:0] column;
        logic [CODE_W-1:0]   depth_code;
        logic [CHAN_W-1:0]   red;
        logic [CHAN_W-1:0]   green;
        logic [CHAN_W-1:0]   blue;
        logic [DISP_W-1:0]   table_value;
    } shift_request_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              covered;
    } view_pixel_t;

    // DUT ports, all inputs known from time zero
    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic [CMD_W-1:0]      s_cmd         = '0;
    logic [COLUMN_W-1:0]   s_column      = '0;
    logic [CODE_W-1:0]     s_depth_code  = '0;
    logic [CHAN_W-1:0]     s_red         = '0;
    logic [CHAN_W-1:0]     s_green       = '0;
    logic [CHAN_W-1:0]     s_blue        = '0;
    logic [DISP_W-1:0]     s_table_value = '0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic [CHAN_W-1:0]     m_out_red;
    logic [CHAN_W-1:0]     m_out_green;
    logic [CHAN_W-1:0]     m_out_blue;
    logic                  m_covered;

    // Shadow state of the view synthesizer
    bit   [COLOR_W-1:0]    row_store [ROW_CAP];
    bit                    cover_map [ROW_CAP];
    bit   [DISP_W-1:0]     disparity_lut [LUT_SIZE];
    bit                    lut_loaded [LUT_SIZE];
    int                    loaded_codes [$];
    logic [RWID_W-1:0]     shadow_row_width = dsvs_pkg::ROW_WIDTH_RST;
    logic [FILL_W-1:0]     shadow_fill      = dsvs_pkg::FILL_EXTRA_RST;
    view_pixel_t           pending_pixels [$];

    // Run statistics
    int cycle_count    = 0;
    int burst_left     = 0;
    int items_sent     = 0;
    int places_done    = 0;
    int places_dropped = 0;
    int reads_done     = 0;
    int reads_covered  = 0;
    int loads_done     = 0;
    int ignored_done   = 0;
    int reg_writes     = 0;
    int results_seen   = 0;
    int error_count    = 0;

    depth_shift_view_synthesis DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_column      (s_column),
        .s_depth_code  (s_depth_code),
        .s_red         (s_red),
        .s_green       (s_green),
        .s_blue        (s_blue),
        .s_table_value (s_table_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_red     (m_out_red),
        .m_out_green   (m_out_green),
        .m_out_blue    (m_out_blue),
        .m_covered     (m_covered)
    );

    always #5 aclk = ~aclk;

    // Cycle counter and run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d reads outstanding",
                     cycle_count, pending_pixels.size());
            $display("depth_shift_view_synthesis: mismatch");
            $finish;
        end
    end

    // Shift one accepted request through the shadow row
    function automatic void synthesize_request(input shift_request_t req);
        int          diff;
        int          target;
        int          span;
        int          i;
        view_pixel_t pix;
        case (req.cmd)
            dsvs_pkg::CMD_PLACE: begin
                places_done++;
                items_sent++;
                diff = int'(req.column) * 16 - int'(disparity_lut[req.depth_code]);
                span = (shadow_row_width > ROW_CAP) ? ROW_CAP : int'(shadow_row_width);
                // a target in (-1, 0) truncates to column zero
                if (diff >= 0)
                    target = diff >>> FRAC_W;
                else if (diff > -16)
                    target = 0;
                else
                    target = -1;
                if (target < 0 || target >= span) begin
                    places_dropped++;
                    return;
                end
                for (i = 0; i <= int'(shadow_fill) && target + i < span; i++)
                    row_store[target + i] = {req.red, req.green, req.blue};
                cover_map[target] = 1'b1;
            end
            dsvs_pkg::CMD_READ: begin
                reads_done++;
                items_sent++;
                pix.red     = row_store[req.column][23:16];
                pix.green   = row_store[req.column][15:8];
                pix.blue    = row_store[req.column][7:0];
                pix.covered = cover_map[req.column];
                if (pix.covered)
                    reads_covered++;
                row_store[req.column] = '0;
                cover_map[req.column] = 1'b0;
                pending_pixels.push_back(pix);
            end
            dsvs_pkg::CMD_LOAD: begin
                loads_done++;
                items_sent++;
                disparity_lut[req.depth_code] = req.table_value;
                if (!lut_loaded[req.depth_code])
                    loaded_codes.push_back(int'(req.depth_code));
                lut_loaded[req.depth_code] = 1'b1;
            end
            default: ignored_done++;
        endcase
    endfunction

    // Send one request, with bursts and random gaps on the input side
    task automatic send_request(input shift_request_t req);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_valid       <= 1'b1;
        s_cmd         <= req.cmd;
        s_column      <= req.column;
        s_depth_code  <= req.depth_code;
        s_red         <= req.red;
        s_green       <= req.green;
        s_blue        <= req.blue;
        s_table_value <= req.table_value;
        do @(posedge aclk); while (!s_ready);
        synthesize_request(req);
    endtask

    // Request builders; fields the command ignores carry random values
    task automatic place_pixel(input int column, input int code,
                               input int red, input int green, input int blue);
        shift_request_t req;
        req.cmd         = dsvs_pkg::CMD_PLACE;
        req.column      = COLUMN_W'(column);
        req.depth_code  = CODE_W'(code);
        req.red         = CHAN_W'(red);
        req.green       = CHAN_W'(green);
        req.blue        = CHAN_W'(blue);
        req.table_value = DISP_W'($urandom_range(0, 16'hFFFF));
        send_request(req);
    endtask

    task automatic read_column(input int column);
        shift_request_t req;
        req.cmd         = dsvs_pkg::CMD_READ;
        req.column      = COLUMN_W'(column);
        req.depth_code  = CODE_W'($urandom_range(0, 16'hFFFF));
        req.red         = CHAN_W'($urandom_range(0, 255));
        req.green       = CHAN_W'($urandom_range(0, 255));
        req.blue        = CHAN_W'($urandom_range(0, 255));
        req.table_value = DISP_W'($urandom_range(0, 16'hFFFF));
        send_request(req);
    endtask

    task automatic load_disparity(input int code, input int value);
        shift_request_t req;
        req.cmd         = dsvs_pkg::CMD_LOAD;
        req.column      = COLUMN_W'($urandom_range(0, 2047));
        req.depth_code  = CODE_W'(code);
        req.red         = CHAN_W'($urandom_range(0, 255));
        req.green       = CHAN_W'($urandom_range(0, 255));
        req.blue        = CHAN_W'($urandom_range(0, 255));
        req.table_value = DISP_W'(value);
        send_request(req);
    endtask

    function automatic int random_color();
        return $urandom_range(0, 255);
    endfunction

    // Register write, only once the block has drained
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int value);
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == dsvs_pkg::CFG_ROW_WIDTH)
            shadow_row_width = value[RWID_W-1:0];
        else
            shadow_fill = value[FILL_W-1:0];
        reg_writes++;
        burst_left = 0;
    endtask

    // Output side stalls: the mode changes when a random-length window runs out
    int stall_mode   = 0;
    int stall_window = 0;
    always @(posedge aclk) begin
        if (stall_window == 0) begin
            stall_mode   <= $urandom_range(0, 3);
            stall_window <= $urandom_range(16, 96);
        end else begin
            stall_window <= stall_window - 1;
        end
        case (stall_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= 1'($urandom_range(0, 1));
            2:       m_ready <= (cycle_count % 4 == 0);
            default: m_ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    task automatic check_pixel();
        view_pixel_t want;
        view_pixel_t got;
        got = {m_out_red, m_out_green, m_out_blue, m_covered};
        results_seen++;
        if (pending_pixels.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_MAX)
                $display("result %0d with no read outstanding: r=%02h g=%02h b=%02h c=%0b",
                         results_seen, got.red, got.green, got.blue, got.covered);
            return;
        end
        want = pending_pixels.pop_front();
        if (got !== want) begin
            error_count++;
            if (error_count <= REPORT_MAX)
                $display("result %0d: expected r=%02h g=%02h b=%02h c=%0b, got %s",
                         results_seen, want.red, want.green, want.blue, want.covered,
                         $sformatf("r=%02h g=%02h b=%02h c=%0b",
                                   got.red, got.green, got.blue, got.covered));
        end
    endtask

    // Result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            check_pixel();
    end

    // Field extremes, fractional disparities, drops and the unused command
    task automatic test_directed_extremes();
        shift_request_t junk;
        load_disparity(16'h0000, 16'h0000);
        load_disparity(16'hFFFF, 16'hFFFF);
        load_disparity(16'h00A5, 16'h0008);   // half a pixel
        load_disparity(16'h5A00, 16'h0010);   // one pixel
        load_disparity(16'h1234, 16'h0017);   // 1.4375 px, fraction dropped
        place_pixel(0,    16'h0000, 255, 255, 255);
        place_pixel(2047, 16'h0000, 8'hAA, 8'h55, 8'h0F);
        place_pixel(0,    16'h00A5, 8'h12, 8'h34, 8'h56);   // just left of zero
        place_pixel(0,    16'h5A00, 0, 0, 0);               // falls off the left
        place_pixel(2047, 16'hFFFF, 0, 0, 0);               // too far left
        place_pixel(10,   16'h1234, 8'h01, 8'h80, 8'hFE);
        junk = '1;
        junk.cmd = CMD_UNUSED;
        send_request(junk);
        read_column(0);
        read_column(2047);
        read_column(8);
        read_column(0);                                     // now cleared
    endtask

    // Row width and fill run at their limits
    task automatic test_register_extremes();
        write_register(dsvs_pkg::CFG_ROW_WIDTH, 0);
        write_register(dsvs_pkg::CFG_FILL_EXTRA, 15);
        place_pixel(5, 16'h0000, 1, 2, 3);                  // empty row drops all
        read_column(5);
        write_register(dsvs_pkg::CFG_ROW_WIDTH, 1);
        place_pixel(0, 16'h0000, 4, 5, 6);                  // fill clipped to one
        read_column(0);
        read_column(1);
        write_register(dsvs_pkg::CFG_ROW_WIDTH, 4095);      // acts as full width
        place_pixel(2047, 16'h0000, 7, 8, 9);
        place_pixel(2040, 16'h0000, 10, 11, 12);            // fill clipped at end
        read_column(2040);
        read_column(2047);
        write_register(dsvs_pkg::CFG_ROW_WIDTH, 100);
        write_register(dsvs_pkg::CFG_FILL_EXTRA, 3);
        load_disparity(16'h0777, 450 * 16);
        place_pixel(500, 16'h0777, 13, 14, 15);             // source past row end
        place_pixel(200, 16'h0000, 16, 17, 18);             // target past row end
        read_column(50);
        read_column(53);
        read_column(200);
    endtask

    // Random rows: fresh settings each phase, placements then a read-out
    task automatic test_random_rows();
        int first_item;
        int phase_start;
        int width;
        int span;
        int window;
        int read_end;
        int count;
        int code;
        int value;
        int c;
        int n;
        int phase_codes [$];
        first_item = items_sent;
        while (items_sent - first_item < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       width = $urandom_range(2048, 4095);
                1:       width = $urandom_range(0, 1);
                2:       width = $urandom_range(81, 2047);
                default: width = $urandom_range(4, 80);
            endcase
            if ($urandom_range(0, 1)) begin
                write_register(dsvs_pkg::CFG_ROW_WIDTH, width);
                write_register(dsvs_pkg::CFG_FILL_EXTRA,
                               ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                            : $urandom_range(0, 3));
            end else begin
                write_register(dsvs_pkg::CFG_FILL_EXTRA,
                               ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                            : $urandom_range(0, 3));
                write_register(dsvs_pkg::CFG_ROW_WIDTH, width);
            end
            span     = (width > ROW_CAP) ? ROW_CAP : width;
            window   = (span == 0) ? 16 : ((span < 64) ? span : 64);
            read_end = (span <= 64) ? window : window + 24;
            phase_start = items_sent;

            // disparities that land inside the window most of the time
            phase_codes.delete();
            count = $urandom_range(6, 12);
            for (n = 0; n < count; n++) begin
                code = $urandom_range(0, 16'hFFFF);
                case ($urandom_range(0, 9))
                    0:       value = $urandom_range(0, 15);
                    1:       value = $urandom_range(0, 16'hFFFF);
                    default: value = $urandom_range(0, (window + 8) * 16);
                endcase
                load_disparity(code, value);
                phase_codes.push_back(code);
            end

            while (items_sent - phase_start < PHASE_ITEMS &&
                   items_sent - first_item < RANDOM_ITEMS) begin
                if ($urandom_range(0, 9) < 7) begin
                    // one row: scattered placements, then read and clear it
                    count = $urandom_range(4, 20);
                    for (n = 0; n < count; n++) begin
                        c = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                                                         : $urandom_range(0, window + 8);
                        code = ($urandom_range(0, 4) != 0)
                             ? phase_codes[$urandom_range(0, phase_codes.size() - 1)]
                             : loaded_codes[$urandom_range(0, loaded_codes.size() - 1)];
                        place_pixel(c, code, random_color(), random_color(),
                                    random_color());
                    end
                    for (c = 0; c < read_end && c < ROW_CAP; c++)
                        read_column(c);
                end else begin
                    // noise: any command, anywhere
                    count = $urandom_range(1, 6);
                    for (n = 0; n < count; n++) begin
                        case ($urandom_range(0, 3))
                            0: place_pixel($urandom_range(0, 2047),
                                           loaded_codes[$urandom_range(0,
                                                        loaded_codes.size() - 1)],
                                           random_color(), random_color(),
                                           random_color());
                            1: read_column($urandom_range(0, 2047));
                            2: load_disparity($urandom_range(0, 16'hFFFF),
                                              $urandom_range(0, 16'hFFFF));
                            default: begin
                                send_request('{cmd: CMD_UNUSED,
                                               column: COLUMN_W'($urandom_range(0, 2047)),
                                               depth_code: CODE_W'($urandom_range(0, 16'hFFFF)),
                                               red: CHAN_W'(random_color()),
                                               green: CHAN_W'(random_color()),
                                               blue: CHAN_W'(random_color()),
                                               table_value: DISP_W'($urandom_range(0, 16'hFFFF))});
                            end
                        endcase
                    end
                end
            end
        end
    endtask

    // Test sequence
    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_extremes();
        test_register_extremes();
        test_random_rows();

        // drain outstanding reads, then let the last placement finish
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("covered %0d placements (%0d off the row), %0d reads (%0d marked), %0d loads",
                 places_done, places_dropped, reads_done, reads_covered, loads_done);
        $display("plus %0d unused-command requests and %0d register writes, %0d errors",
                 ignored_done, reg_writes, error_count);
        if (error_count == 0) begin
            $display("depth_shift_view_synthesis: match");
        end else begin
            $display("depth_shift_view_synthesis: mismatch");
        end
        $finish;
    end

endmodule

@@ depth_shift_view_synthesis.f @@
hdl/dsvs_pkg.sv
hdl/depth_shift_view_synthesis.sv
bench/tb_depth_shift_view_synthesis.sv
